// ----- rtl/core/cps_pkg.sv -----
// Shared types and constants for the complement protected byte store.
`default_nettype none

package cps_pkg;

  // Number of bytes in the store and the address width that follows from it.
  localparam int DATA_BYTES = 128;
  localparam int ADDR_W     = $clog2(DATA_BYTES);

  // Per-transaction status codes.
  typedef enum logic [1:0] {
    ST_SUCCESS   = 2'd0,
    ST_BAD_RANGE = 2'd1,
    ST_MISMATCH  = 2'd2
  } cps_status_t;

  // Command transaction: one byte of a transfer.
  typedef struct packed {
    logic       mode;
    logic [6:0] start_address;
    logic [7:0] transfer_length;
    logic [7:0] write_data;
  } cps_cmd_t;

  // Result transaction: one per command.
  typedef struct packed {
    cps_status_t status;
    logic [7:0]  read_data;
    logic [15:0] complement_errors;
    logic        transfer_last;
  } cps_result_t;

  // Request from the control pipeline to the pair memory.
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_word;
  } cps_mem_req_t;

  localparam logic MODE_WRITE = 1'b1;

endpackage

`default_nettype wire

// ----- rtl/core/cps_pair_mem.sv -----
// Data/complement pair memory with erased-state tracking and write forwarding.
`default_nettype none

module cps_pair_mem (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cps_pkg::cps_mem_req_t req,
  output logic [15:0]               rd_word
);

  logic [15:0]                      mem [cps_pkg::DATA_BYTES];
  logic [cps_pkg::DATA_BYTES-1:0]   written;
  logic [15:0]                      mem_q;
  logic                             valid_q;
  logic                             fwd_hit;
  logic [15:0]                      fwd_word;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_word;
    end
    if (req.rd_en) begin
      mem_q    <= mem[req.rd_addr];
      fwd_word <= req.wr_word;
    end
  end

  // A byte never written since reset reads as erased (all ones).
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      valid_q <= 1'b0;
      fwd_hit <= 1'b0;
    end else begin
      if (req.wr_en) begin
        written[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        valid_q <= written[req.rd_addr];
        fwd_hit <= req.wr_en && (req.wr_addr == req.rd_addr);
      end
    end
  end

  assign rd_word = fwd_hit ? fwd_word : (valid_q ? mem_q : 16'hFFFF);

endmodule

`default_nettype wire

// ----- rtl/core/complement_protected_byte_store.sv -----
// Top level of the complement protected byte store.
// Results: an accepted command passes through the stage-one register and then the
// result register, which holds while its result is not taken and so stalls stage one.
// Throughput: one transaction per cycle while results drain. The pair memory has one
// read and one write port, so a new read shares a cycle with the last write-back.
// Reset (synchronous): every byte reads as erased through 128 written flags,
// so no clearing pass is needed; offset, status and error count return to zero.
`default_nettype none

module complement_protected_byte_store (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cmd_valid,
  output logic                      cmd_ready,
  input  wire cps_pkg::cps_cmd_t    cmd,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output cps_pkg::cps_result_t      result
);

  // Stage one holds an accepted command while its memory read completes.
  logic                  s1_valid;
  cps_pkg::cps_cmd_t     s1_cmd;
  logic [cps_pkg::ADDR_W-1:0] s1_addr;
  logic                  s1_bad;
  logic                  s1_last;

  // Transfer tracking. The offset runs at accept time since it depends only
  // on the command fields; the sticky status is resolved in stage two.
  logic [7:0]            offset;
  cps_pkg::cps_status_t  transfer_status;
  logic [15:0]           mismatch_count;

  logic                  cmd_fire;
  logic                  s1_advance;
  logic [8:0]            addr_full;
  logic [8:0]            range_end;
  logic                  range_bad;
  logic                  is_last;

  cps_pkg::cps_mem_req_t mem_req;
  logic [15:0]           rd_word;

  cps_pkg::cps_status_t  st_next;
  logic [7:0]            rd_byte;
  logic [15:0]           count_next;
  logic                  do_write;

  // Stage one may move into the result register when it is empty or drained.
  assign s1_advance = s1_valid && (!result_valid || result_ready);
  assign cmd_ready  = !s1_valid || s1_advance;
  assign cmd_fire   = cmd_valid && cmd_ready;

  assign addr_full = {2'b00, cmd.start_address} + {1'b0, offset};
  assign range_end = {2'b00, cmd.start_address} + {1'b0, cmd.transfer_length};
  assign range_bad = (cmd.transfer_length == 8'd0)
                  || (range_end > 9'(cps_pkg::DATA_BYTES))
                  || (addr_full >= 9'(cps_pkg::DATA_BYTES));
  assign is_last   = ({1'b0, offset} + 9'd1) >= {1'b0, cmd.transfer_length};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      offset   <= '0;
    end else begin
      if (cmd_fire) begin
        s1_valid <= 1'b1;
        offset   <= is_last ? 8'd0 : offset + 8'd1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      s1_cmd  <= cmd;
      s1_addr <= addr_full[cps_pkg::ADDR_W-1:0];
      s1_bad  <= range_bad;
      s1_last <= is_last;
    end
  end

  // Stage two: apply the sticky status, check the pair or store a new one.
  always_comb begin
    st_next    = transfer_status;
    rd_byte    = 8'd0;
    count_next = mismatch_count;
    do_write   = 1'b0;
    if (transfer_status == cps_pkg::ST_SUCCESS) begin
      if (s1_bad) begin
        st_next = cps_pkg::ST_BAD_RANGE;
      end else if (s1_cmd.mode == cps_pkg::MODE_WRITE) begin
        do_write = 1'b1;
      end else if (rd_word[7:0] != ~rd_word[15:8]) begin
        st_next = cps_pkg::ST_MISMATCH;
        if (mismatch_count != 16'hFFFF) begin
          count_next = mismatch_count + 16'd1;
        end
      end else begin
        rd_byte = rd_word[7:0];
      end
    end
  end

  // A new read and the write-back of the previous command can hit the same
  // byte in one cycle; the memory forwards the write word in that case.
  always_comb begin
    mem_req.rd_en   = cmd_fire;
    mem_req.rd_addr = addr_full[cps_pkg::ADDR_W-1:0];
    mem_req.wr_en   = s1_advance && do_write;
    mem_req.wr_addr = s1_addr;
    mem_req.wr_word = {~s1_cmd.write_data, s1_cmd.write_data};
  end

  cps_pair_mem u_pair_mem (
    .clk     (clk),
    .rst     (rst),
    .req     (mem_req),
    .rd_word (rd_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      transfer_status <= cps_pkg::ST_SUCCESS;
      mismatch_count  <= '0;
      result_valid    <= 1'b0;
    end else begin
      if (s1_advance) begin
        transfer_status <= s1_last ? cps_pkg::ST_SUCCESS : st_next;
        mismatch_count  <= count_next;
        result_valid    <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      result.status            <= st_next;
      result.read_data         <= (st_next == cps_pkg::ST_SUCCESS) ? rd_byte : 8'd0;
      result.complement_errors <= count_next;
      result.transfer_last     <= s1_last;
    end
  end

  // A failed transaction never returns data.
  a_no_data_on_error: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.status != cps_pkg::ST_SUCCESS) |-> result.read_data == 8'd0)
    else $error("data returned with a failing status");

  // The error count never goes backward.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> mismatch_count >= $past(mismatch_count))
    else $error("complement error count decreased");

  // A memory write only comes from a command that is leaving stage one.
  a_write_from_stage: assert property (@(posedge clk) disable iff (rst)
    mem_req.wr_en |-> s1_valid && (!result_valid || result_ready))
    else $error("memory write without an advancing command");

  // The sticky status is clear whenever a transfer has just ended.
  a_status_cleared: assert property (@(posedge clk) disable iff (rst)
    s1_advance && s1_last |=> transfer_status == cps_pkg::ST_SUCCESS)
    else $error("transfer status survived the last transaction");

endmodule

`default_nettype wire
